### rtl/core/qrpm_pkg.sv
// ----------------------------------------------------------------------------
// qrpm_pkg
// Shared types and constants of the quadrilateral region pixel mask.
// ----------------------------------------------------------------------------
package qrpm_pkg;

   localparam int COORD_BITS    = 12;
   localparam int EDGES         = 4;
   localparam int EDGE_BITS     = $clog2(EDGES);
   localparam int DIFF_BITS     = COORD_BITS + 1;
   localparam int PROD_BITS     = 2 * DIFF_BITS;
   localparam int CROSS_BITS    = PROD_BITS + 1;
   localparam int FRAME_BITS    = COORD_BITS + 1;
   localparam int MASK_BITS     = 8;
   localparam int CORNER_BITS   = 2 * COORD_BITS;
   localparam int CSR_DATA_BITS = CORNER_BITS;
   localparam int CSR_IDX_BITS  = 3;

   localparam logic [FRAME_BITS-1:0] FRAME_WIDTH_RESET  = FRAME_BITS'(640);
   localparam logic [FRAME_BITS-1:0] FRAME_HEIGHT_RESET = FRAME_BITS'(480);
   localparam logic [MASK_BITS-1:0]  FOREGROUND_RESET   = MASK_BITS'(255);

   typedef enum logic [CSR_IDX_BITS-1:0] {
      REG_TOP_LEFT     = 3'd0,
      REG_TOP_RIGHT    = 3'd1,
      REG_BOTTOM_RIGHT = 3'd2,
      REG_BOTTOM_LEFT  = 3'd3,
      REG_FRAME_WIDTH  = 3'd4,
      REG_FRAME_HEIGHT = 3'd5,
      REG_FOREGROUND   = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic [COORD_BITS-1:0] y;
      logic [COORD_BITS-1:0] x;
   } point_type;

   typedef struct packed {
      point_type [EDGES-1:0]  corner;
      logic [FRAME_BITS-1:0]  frame_width;
      logic [FRAME_BITS-1:0]  frame_height;
      logic [MASK_BITS-1:0]   foreground_value;
   } cfg_type;

   typedef struct packed {
      logic [COORD_BITS-1:0] pixel_row;
      logic [COORD_BITS-1:0] pixel_col;
   } req_type;

   typedef struct packed {
      logic [MASK_BITS-1:0] mask_value;
      logic                 inside_res;
      logic                 in_frame;
   } rsp_type;

   typedef struct packed {
      logic [EDGES-1:0][PROD_BITS-1:0] prod_a;
      logic [EDGES-1:0][PROD_BITS-1:0] prod_b;
      logic                            in_frame;
   } prod_stage_type;

endpackage

### rtl/core/qrpm_csr.sv
// ----------------------------------------------------------------------------
// qrpm_csr
// Configuration registers: corners, frame size and foreground value.
// ----------------------------------------------------------------------------
module qrpm_csr (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [qrpm_pkg::CSR_IDX_BITS-1:0]     csr_index,
   input  logic [qrpm_pkg::CSR_DATA_BITS-1:0]    csr_data,
   output qrpm_pkg::cfg_type                     cfg
);

   qrpm_pkg::cfg_type cfg_ff;
   qrpm_pkg::cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            qrpm_pkg::REG_TOP_LEFT:     cfg_in.corner[0] = qrpm_pkg::point_type'(csr_data);
            qrpm_pkg::REG_TOP_RIGHT:    cfg_in.corner[1] = qrpm_pkg::point_type'(csr_data);
            qrpm_pkg::REG_BOTTOM_RIGHT: cfg_in.corner[2] = qrpm_pkg::point_type'(csr_data);
            qrpm_pkg::REG_BOTTOM_LEFT:  cfg_in.corner[3] = qrpm_pkg::point_type'(csr_data);
            qrpm_pkg::REG_FRAME_WIDTH:
               cfg_in.frame_width = csr_data[qrpm_pkg::FRAME_BITS-1:0];
            qrpm_pkg::REG_FRAME_HEIGHT:
               cfg_in.frame_height = csr_data[qrpm_pkg::FRAME_BITS-1:0];
            qrpm_pkg::REG_FOREGROUND:
               cfg_in.foreground_value = csr_data[qrpm_pkg::MASK_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.corner           <= '0;
         cfg_ff.frame_width      <= qrpm_pkg::FRAME_WIDTH_RESET;
         cfg_ff.frame_height     <= qrpm_pkg::FRAME_HEIGHT_RESET;
         cfg_ff.foreground_value <= qrpm_pkg::FOREGROUND_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

### rtl/core/qrpm_cross.sv
// ----------------------------------------------------------------------------
// qrpm_cross
// Edge product stage: both cross-product terms of every quad edge and the
// frame check, registered.
// ----------------------------------------------------------------------------
module qrpm_cross (
   input  logic                     clock,
   input  logic                     reset,
   input  qrpm_pkg::cfg_type        cfg,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  qrpm_pkg::req_type        in_pix,
   output logic                     out_valid,
   input  logic                     out_ready,
   output qrpm_pkg::prod_stage_type out_stage
);

   logic                     valid_ff;
   qrpm_pkg::prod_stage_type stage_ff;
   qrpm_pkg::prod_stage_type stage_in;
   logic                     advance;

   logic signed [qrpm_pkg::DIFF_BITS-1:0] dx   [qrpm_pkg::EDGES];
   logic signed [qrpm_pkg::DIFF_BITS-1:0] dy   [qrpm_pkg::EDGES];
   logic signed [qrpm_pkg::DIFF_BITS-1:0] rdx  [qrpm_pkg::EDGES];
   logic signed [qrpm_pkg::DIFF_BITS-1:0] rdy  [qrpm_pkg::EDGES];
   logic signed [qrpm_pkg::PROD_BITS-1:0] pa   [qrpm_pkg::EDGES];
   logic signed [qrpm_pkg::PROD_BITS-1:0] pb   [qrpm_pkg::EDGES];

   assign in_ready  = !valid_ff || out_ready;
   assign advance   = in_valid && in_ready;
   assign out_valid = valid_ff;
   assign out_stage = stage_ff;

   always_comb begin
      qrpm_pkg::point_type a;
      qrpm_pkg::point_type b;
      logic [qrpm_pkg::EDGE_BITS-1:0] ia;
      logic [qrpm_pkg::EDGE_BITS-1:0] ib;
      stage_in = '0;
      for (int e = 0; e < qrpm_pkg::EDGES; e++) begin
         ia     = qrpm_pkg::EDGE_BITS'(e);
         ib     = ia + 1'b1;
         a      = cfg.corner[ia];
         b      = cfg.corner[ib];
         dx[e]  = $signed({1'b0, b.x}) - $signed({1'b0, a.x});
         dy[e]  = $signed({1'b0, b.y}) - $signed({1'b0, a.y});
         rdy[e] = $signed({1'b0, in_pix.pixel_row}) - $signed({1'b0, a.y});
         rdx[e] = $signed({1'b0, in_pix.pixel_col}) - $signed({1'b0, a.x});
         pa[e]  = qrpm_pkg::PROD_BITS'(dx[e]) * qrpm_pkg::PROD_BITS'(rdy[e]);
         pb[e]  = qrpm_pkg::PROD_BITS'(dy[e]) * qrpm_pkg::PROD_BITS'(rdx[e]);
         stage_in.prod_a[e] = pa[e];
         stage_in.prod_b[e] = pb[e];
      end
      stage_in.in_frame =
         ({1'b0, in_pix.pixel_row} < cfg.frame_height) &&
         ({1'b0, in_pix.pixel_col} < cfg.frame_width);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (advance) begin
         stage_ff <= stage_in;
      end
   end

   a_fill: assert property (@(posedge clock) disable iff (reset)
      advance |=> valid_ff)
      else $error("product stage lost an accepted beat");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      valid_ff && !out_ready |=> valid_ff && $stable(stage_ff))
      else $error("product stage changed while stalled");

endmodule

### rtl/core/qrpm_decide.sv
// ----------------------------------------------------------------------------
// qrpm_decide
// Result stage: edge signs, inside and frame flags, mask value register.
// ----------------------------------------------------------------------------
module qrpm_decide (
   input  logic                     clock,
   input  logic                     reset,
   input  qrpm_pkg::cfg_type        cfg,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  qrpm_pkg::prod_stage_type in_stage,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output qrpm_pkg::rsp_type        rsp_data
);

   logic                                   valid_ff;
   qrpm_pkg::rsp_type                      rsp_ff;
   qrpm_pkg::rsp_type                      rsp_in;
   logic [qrpm_pkg::EDGES-1:0]             edge_ok;
   logic signed [qrpm_pkg::CROSS_BITS-1:0] cross_sum [qrpm_pkg::EDGES];

   assign in_ready  = !valid_ff || rsp_ready;
   assign rsp_valid = valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      for (int e = 0; e < qrpm_pkg::EDGES; e++) begin
         cross_sum[e] = qrpm_pkg::CROSS_BITS'($signed(in_stage.prod_a[e])) -
                        qrpm_pkg::CROSS_BITS'($signed(in_stage.prod_b[e]));
         edge_ok[e] = !cross_sum[e][qrpm_pkg::CROSS_BITS-1];
      end
      rsp_in.inside_res = &edge_ok;
      rsp_in.in_frame   = in_stage.in_frame;
      rsp_in.mask_value = (rsp_in.inside_res && rsp_in.in_frame) ?
                          cfg.foreground_value : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_valid && in_ready) begin
         rsp_ff <= rsp_in;
      end
   end

   a_mask_inside: assert property (@(posedge clock) disable iff (reset)
      valid_ff && rsp_ff.mask_value != '0 |-> rsp_ff.inside_res && rsp_ff.in_frame)
      else $error("nonzero mask for a pixel outside the region");

   a_fill: assert property (@(posedge clock) disable iff (reset)
      in_valid && in_ready |=> valid_ff)
      else $error("result stage lost an accepted beat");

endmodule

### rtl/core/quad_region_pixel_mask.sv
// ----------------------------------------------------------------------------
// quad_region_pixel_mask
// Pipeline: a req beat passes the input, product and result registers to rsp_valid.
// Throughput: one pixel per cycle while rsp_ready is high; the three stages pass beats back to back.
// The product stage holds eight 13x13 multiplies, one per term.
// Reset: synchronous, clears all stage valids; corners to 0, frame 640x480,
// foreground 255.
// ----------------------------------------------------------------------------
module quad_region_pixel_mask (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  qrpm_pkg::req_type                  req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output qrpm_pkg::rsp_type                  rsp_data,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [qrpm_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  logic [qrpm_pkg::CSR_DATA_BITS-1:0] csr_data
);

   qrpm_pkg::cfg_type        cfg;
   logic                     req_valid_ff;
   qrpm_pkg::req_type        req_ff;
   logic                     cross_ready;
   logic                     prod_valid;
   logic                     prod_ready;
   qrpm_pkg::prod_stage_type prod_stage;

   assign req_ready = !req_valid_ff || cross_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (req_ready) begin
         req_valid_ff <= req_valid;
      end
      if (req_valid && req_ready) begin
         req_ff <= req_data;
      end
   end

   qrpm_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   qrpm_cross u_cross (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (req_valid_ff),
      .in_ready  (cross_ready),
      .in_pix    (req_ff),
      .out_valid (prod_valid),
      .out_ready (prod_ready),
      .out_stage (prod_stage)
   );

   qrpm_decide u_decide (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (prod_valid),
      .in_ready  (prod_ready),
      .in_stage  (prod_stage),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

### bench/testbench.sv
// ----------------------------------------------------------------------------
// quad_region_pixel_mask testbench
// Sends pixel coordinates through the request channel in random bursts and
// classifies each one in a local copy of the quad's edge half-plane tests and
// the frame bounds. Response beats are checked in order, field by field.
// Regions and frame sizes are reprogrammed between phases while the pipeline
// is empty. The phases cover degenerate, reversed, collinear and full-frame
// corners, and zero, tiny and oversized frames.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int COORD_MAX        = (1 << qrpm_pkg::COORD_BITS) - 1;
   localparam int SETTLE_CYCLES    = 8;
   localparam int RANDOM_PHASES    = 14;
   localparam int PIXELS_PER_PHASE = 120;
   localparam int LONG_HOLD        = 300;
   localparam int HOLD_SPACING     = 700;
   localparam int WATCHDOG_LIMIT   = 4000;
   localparam logic [qrpm_pkg::CSR_IDX_BITS-1:0] REG_UNUSED = 3'd7;

   logic                               clock     = 1'b0;
   logic                               reset     = 1'b1;
   logic                               req_valid = 1'b0;
   logic                               req_ready;
   qrpm_pkg::req_type                  req_data  = '0;
   logic                               rsp_valid;
   logic                               rsp_ready = 1'b0;
   qrpm_pkg::rsp_type                  rsp_data;
   logic                               csr_valid = 1'b0;
   logic                               csr_ready;
   logic [qrpm_pkg::CSR_IDX_BITS-1:0]  csr_index = '0;
   logic [qrpm_pkg::CSR_DATA_BITS-1:0] csr_data  = '0;

   qrpm_pkg::req_type pending_pixels[$];
   qrpm_pkg::rsp_type predicted_masks[$];
   qrpm_pkg::cfg_type region;
   int      mismatches = 0;
   int      corner_x[qrpm_pkg::EDGES];
   int      corner_y[qrpm_pkg::EDGES];

   int burst_left;
   int gap_left;
   int delivered;
   int hold_left;
   int next_long_hold = 400;
   int pattern_pos;
   logic [15:0] stall_pattern;
   int quiet_cycles = 0;

   quad_region_pixel_mask dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #10 clock = ~clock;

   function automatic qrpm_pkg::rsp_type classify_pixel(qrpm_pkg::req_type pixel);
      longint  ax, ay, bx, by, px, py, cross_sum;
      logic    in_region, framed;
      qrpm_pkg::rsp_type result;
      px = pixel.pixel_col;
      py = pixel.pixel_row;
      in_region = 1'b1;
      for (int e = 0; e < qrpm_pkg::EDGES; e++) begin
         ax = region.corner[e].x;
         ay = region.corner[e].y;
         bx = region.corner[(e + 1) % qrpm_pkg::EDGES].x;
         by = region.corner[(e + 1) % qrpm_pkg::EDGES].y;
         cross_sum = (bx - ax) * (py - ay) - (by - ay) * (px - ax);
         if (cross_sum < 0) in_region = 1'b0;
      end
      framed = (pixel.pixel_row < region.frame_height) &&
               (pixel.pixel_col < region.frame_width);
      result.mask_value = (in_region && framed) ? region.foreground_value : '0;
      result.inside_res = in_region;
      result.in_frame   = framed;
      return result;
   endfunction

   function automatic int fit_coord(int v);
      return (v < 0) ? 0 : (v > COORD_MAX) ? COORD_MAX : v;
   endfunction

   function automatic int wobble(int span);
      return int'($urandom_range(0, 2 * span)) - span;
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_data  <= '0;
         burst_left = 0;
         gap_left   = 0;
      end else if (!req_valid || req_ready) begin
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (pending_pixels.size() != 0) begin
            req_data  <= pending_pixels.pop_front();
            req_valid <= 1'b1;
            if (burst_left > 0) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(1, 48);
               gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // response receiver
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_pattern = '1;
         pattern_pos   = 0;
         delivered     = 0;
         hold_left     = 0;
      end else begin
         if (rsp_valid && rsp_ready) delivered++;
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (delivered >= next_long_hold) begin
            next_long_hold += HOLD_SPACING;
            hold_left = LONG_HOLD;
            rsp_ready <= 1'b0;
         end else begin
            if (pattern_pos == 0) begin
               case ($urandom_range(0, 3))
                  0: stall_pattern = '1;
                  1: stall_pattern = 16'($urandom());
                  2: stall_pattern = 16'($urandom()) & 16'($urandom());
                  default: stall_pattern = 16'($urandom()) | 16'($urandom());
               endcase
            end
            rsp_ready <= stall_pattern[pattern_pos];
            pattern_pos = (pattern_pos + 1) % 16;
         end
      end
   end

   // monitor: predict on request beats, check response beats, track registers
   always @(posedge clock) begin : check_results
      qrpm_pkg::rsp_type want;
      qrpm_pkg::rsp_type got;
      if (reset) begin
         region.corner           = '0;
         region.frame_width      = qrpm_pkg::FRAME_WIDTH_RESET;
         region.frame_height     = qrpm_pkg::FRAME_HEIGHT_RESET;
         region.foreground_value = qrpm_pkg::FOREGROUND_RESET;
      end else begin
         if (req_valid && req_ready) begin
            predicted_masks = {predicted_masks, classify_pixel(req_data)};
         end
         if (rsp_valid && rsp_ready) begin
            got = rsp_data;
            if (predicted_masks.size() == 0) begin
               $error("rsp beat with no pixel outstanding: %h", got);
               mismatches++;
            end else begin
               want = predicted_masks.pop_front();
               if (got.mask_value !== want.mask_value) begin
                  $error("mask_value: expected %0d, got %0d", want.mask_value, got.mask_value);
                  mismatches++;
               end
               if (got.inside_res !== want.inside_res) begin
                  $error("inside_res: expected %0d, got %0d", want.inside_res, got.inside_res);
                  mismatches++;
               end
               if (got.in_frame !== want.in_frame) begin
                  $error("in_frame: expected %0d, got %0d", want.in_frame, got.in_frame);
                  mismatches++;
               end
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               qrpm_pkg::REG_TOP_LEFT, qrpm_pkg::REG_TOP_RIGHT,
               qrpm_pkg::REG_BOTTOM_RIGHT, qrpm_pkg::REG_BOTTOM_LEFT:
                  region.corner[csr_index[qrpm_pkg::EDGE_BITS-1:0]] =
                     csr_data[qrpm_pkg::CORNER_BITS-1:0];
               qrpm_pkg::REG_FRAME_WIDTH:
                  region.frame_width = csr_data[qrpm_pkg::FRAME_BITS-1:0];
               qrpm_pkg::REG_FRAME_HEIGHT:
                  region.frame_height = csr_data[qrpm_pkg::FRAME_BITS-1:0];
               qrpm_pkg::REG_FOREGROUND:
                  region.foreground_value = csr_data[qrpm_pkg::MASK_BITS-1:0];
               default: ;
            endcase
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("quad_region_pixel_mask test failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic offer_pixel(int row, int col);
      qrpm_pkg::req_type pixel;
      pixel.pixel_row = qrpm_pkg::COORD_BITS'(fit_coord(row));
      pixel.pixel_col = qrpm_pkg::COORD_BITS'(fit_coord(col));
      pending_pixels = {pending_pixels, pixel};
   endtask

   task automatic wait_idle();
      do @(negedge clock);
      while (pending_pixels.size() != 0 || req_valid || predicted_masks.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_register(logic [qrpm_pkg::CSR_IDX_BITS-1:0] index,
                                 logic [qrpm_pkg::CSR_DATA_BITS-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   task automatic set_corners(int x0, int y0, int x1, int y1, int x2, int y2, int x3, int y3);
      corner_x[0] = fit_coord(x0);
      corner_y[0] = fit_coord(y0);
      corner_x[1] = fit_coord(x1);
      corner_y[1] = fit_coord(y1);
      corner_x[2] = fit_coord(x2);
      corner_y[2] = fit_coord(y2);
      corner_x[3] = fit_coord(x3);
      corner_y[3] = fit_coord(y3);
   endtask

   function automatic logic [qrpm_pkg::CSR_DATA_BITS-1:0] corner_word(int k);
      return {qrpm_pkg::COORD_BITS'(corner_y[k]), qrpm_pkg::COORD_BITS'(corner_x[k])};
   endfunction

   task automatic program_region(int fw, int fh, int fg);
      write_register(qrpm_pkg::REG_TOP_LEFT, corner_word(0));
      write_register(qrpm_pkg::REG_TOP_RIGHT, corner_word(1));
      write_register(qrpm_pkg::REG_BOTTOM_RIGHT, corner_word(2));
      write_register(qrpm_pkg::REG_BOTTOM_LEFT, corner_word(3));
      write_register(qrpm_pkg::REG_FRAME_WIDTH,
                     {11'($urandom()), qrpm_pkg::FRAME_BITS'(fw)});
      write_register(qrpm_pkg::REG_FRAME_HEIGHT,
                     {11'($urandom()), qrpm_pkg::FRAME_BITS'(fh)});
      write_register(qrpm_pkg::REG_FOREGROUND,
                     {16'($urandom()), qrpm_pkg::MASK_BITS'(fg)});
      write_register(REG_UNUSED, qrpm_pkg::CSR_DATA_BITS'($urandom()));
      @(negedge clock);
   endtask

   task automatic offer_random_pixels(int count, int fw, int fh);
      int min_x, max_x, min_y, max_y, k, row, col;
      min_x = COORD_MAX;
      min_y = COORD_MAX;
      max_x = 0;
      max_y = 0;
      for (int e = 0; e < qrpm_pkg::EDGES; e++) begin
         if (corner_x[e] < min_x) min_x = corner_x[e];
         if (corner_x[e] > max_x) max_x = corner_x[e];
         if (corner_y[e] < min_y) min_y = corner_y[e];
         if (corner_y[e] > max_y) max_y = corner_y[e];
      end
      repeat (count) begin
         k = $urandom_range(0, qrpm_pkg::EDGES - 1);
         row = min_y - 3 + int'($urandom_range(0, max_y - min_y + 6));
         col = min_x - 3 + int'($urandom_range(0, max_x - min_x + 6));
         case ($urandom_range(0, 7))
            0: begin
               row = $urandom_range(0, COORD_MAX);
               col = $urandom_range(0, COORD_MAX);
            end
            1: begin
               row = corner_y[k] + wobble(2);
               col = corner_x[k] + wobble(2);
            end
            2: row = fh - 1 + wobble(1);
            3: col = fw - 1 + wobble(1);
            default: ;
         endcase
         offer_pixel(row, col);
      end
   endtask

   initial begin
      int fw, fh, fg, cx, cy, hw, hh, jit;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // coincident corners after reset: every pixel inside, 640x480 frame
      offer_pixel(0, 0);
      offer_pixel(479, 639);
      offer_pixel(480, 639);
      offer_pixel(479, 640);
      offer_pixel(COORD_MAX, COORD_MAX);
      offer_pixel('haaa, 'h555);
      offer_pixel('h555, 'haaa);
      wait_idle();

      // skewed quad with a vertical left edge
      set_corners(100, 50, 300, 60, 320, 250, 100, 240);
      program_region(4096, 4096, 'h5a);
      for (int k = 0; k < qrpm_pkg::EDGES; k++) offer_pixel(corner_y[k], corner_x[k]);
      offer_pixel(49, 100);
      offer_pixel(55, 200);
      offer_pixel(54, 200);
      offer_pixel(150, 100);
      offer_pixel(150, 99);
      offer_pixel(150, 200);
      offer_pixel(0, 0);
      offer_pixel(COORD_MAX, COORD_MAX);

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         wait_idle();
         fw  = $urandom_range(1, 4096);
         fh  = $urandom_range(1, 4096);
         fg  = $urandom_range(0, 255);
         cx  = $urandom_range(0, COORD_MAX);
         cy  = $urandom_range(0, COORD_MAX);
         hw  = $urandom_range(1, 300);
         hh  = $urandom_range(1, 300);
         jit = $urandom_range(0, 1) ? 0 : hw / 3;
         set_corners(cx - hw + wobble(jit), cy - hh + wobble(jit),
                     cx + hw + wobble(jit), cy - hh + wobble(jit),
                     cx + hw + wobble(jit), cy + hh + wobble(jit),
                     cx - hw + wobble(jit), cy + hh + wobble(jit));
         case (phase)
            0: fw = 0;
            1: begin
               set_corners(0, 0, COORD_MAX, 0, COORD_MAX, COORD_MAX, 0, COORD_MAX);
               fw = 8191;
               fh = 4097;
               fg = 0;
            end
            2: set_corners(cx, cy, cx, cy, cx, cy, cx, cy);
            3: set_corners(cx, cy, cx + hw, cy + hh, cx + 2 * hw, cy + 2 * hh,
                           cx + 3 * hw, cy + 3 * hh);
            4: set_corners(cx - hw, cy - hh, cx - hw, cy + hh, cx + hw, cy + hh,
                           cx + hw, cy - hh);
            5: begin
               fw = 1;
               fh = 1;
               fg = 255;
            end
            6: set_corners($urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                           $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                           $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                           $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX));
            7: fh = 0;
            default: ;
         endcase
         program_region(fw, fh, fg);
         offer_random_pixels(PIXELS_PER_PHASE, fw, fh);
      end

      wait_idle();
      if (mismatches == 0 && predicted_masks.size() == 0) begin
         $display("quad_region_pixel_mask test passed");
      end else begin
         $display("quad_region_pixel_mask test failed");
      end
      $finish;
   end

endmodule
